### rtl/lrt_pkg.sv
// Shared types and constants of the linked row table with undo.
// Used by the controller, the datapath and the top level; depends on nothing.
package lrt_pkg;

    // Widths of the request and result fields.
    localparam int OP_W        = 3;
    localparam int STEP_W      = 10;
    localparam int ROW_FIELD_W = 10;
    localparam int ROW_COUNT_W = 11;
    localparam int STATUS_W    = 2;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 16;
    localparam int CFG_DATA_W  = 11;

    // Largest table the row fields can address.
    localparam int ROW_LIMIT = 1024;

    // Register values after reset.
    localparam int RESET_ROW_COUNT = 8;
    localparam int RESET_START_ROW = 0;

    typedef enum logic [OP_W-1:0] {
        OP_INIT   = 3'd0,
        OP_UP     = 3'd1,
        OP_DOWN   = 3'd2,
        OP_DELETE = 3'd3,
        OP_UNDO   = 3'd4,
        OP_QUERY  = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK            = 2'd0,
        ST_EMPTY_HISTORY = 2'd1,
        ST_REFUSED       = 2'd2,
        ST_EDGE          = 2'd3
    } status_t;

    typedef enum logic {
        CFG_ROW_COUNT = 1'b0,
        CFG_START_ROW = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_SWEEP,
        S_IDLE,
        S_MOVE_RD,
        S_MOVE_STEP,
        S_DEL_RD,
        S_DEL_WR,
        S_UNDO_HIST,
        S_UNDO_LINK,
        S_UNDO_WR,
        S_QUERY_RD,
        S_QUERY_TAKE,
        S_DONE
    } state_t;

    // Where the link memories are read.
    typedef enum logic [1:0] {
        ADDR_CURSOR,
        ADDR_LINK,
        ADDR_HIST
    } addr_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load_item;
        status_t   status_code;
        logic      init_start;
        logic      sweep_write;
        addr_sel_t addr_sel;
        logic      link_read;
        logic      dir_up;
        logic      move_advance;
        logic      set_edge;
        logic      del_write;
        logic      hist_read;
        logic      undo_write;
        logic      mark_read;
        logic      mark_take;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic live_le1;
        logic hist_empty;
        logic steps_zero;
        logic steps_one;
        logic link_valid;
        logic sweep_last;
    } dp_stat_t;

endpackage

### rtl/lrt_ctrl.sv
// Sequencing state machine of the linked row table with undo.
// Depends on lrt_pkg; drives the datapath through dp_cmd_t and reads dp_stat_t.
module lrt_ctrl
    import lrt_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [OP_W-1:0] op_code,
    input  dp_stat_t        stat,
    input  logic            out_free,
    output dp_cmd_t         cmd,
    output logic            emit
);

    state_t state_reg, state_next;
    logic   from_op_reg;
    logic   dir_up_reg;
    logic   accept;
    op_t    op_in;

    assign op_in  = op_t'(op_code);
    assign accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_INIT;
            from_op_reg <= 1'b0;
            dir_up_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                from_op_reg <= 1'b1;
                dir_up_reg  <= (op_in == OP_UP);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:
                state_next = S_SWEEP;
            S_SWEEP:
                if (stat.sweep_last)
                    state_next = from_op_reg ? S_DONE : S_IDLE;
            S_IDLE:
                if (accept)
                begin
                    case (op_in)
                        OP_INIT:          state_next = S_INIT;
                        OP_UP, OP_DOWN:   state_next = S_MOVE_RD;
                        OP_DELETE:        state_next = stat.live_le1 ? S_DONE : S_DEL_RD;
                        OP_UNDO:          state_next = stat.hist_empty ? S_DONE : S_UNDO_HIST;
                        OP_QUERY:         state_next = S_QUERY_RD;
                        default:          state_next = S_DONE;
                    endcase
                end
            S_MOVE_RD:
                state_next = stat.steps_zero ? S_DONE : S_MOVE_STEP;
            S_MOVE_STEP:
                if (!stat.link_valid || stat.steps_one)
                    state_next = S_DONE;
            S_DEL_RD:     state_next = S_DEL_WR;
            S_DEL_WR:     state_next = S_DONE;
            S_UNDO_HIST:  state_next = S_UNDO_LINK;
            S_UNDO_LINK:  state_next = S_UNDO_WR;
            S_UNDO_WR:    state_next = S_DONE;
            S_QUERY_RD:   state_next = S_QUERY_TAKE;
            S_QUERY_TAKE: state_next = S_DONE;
            S_DONE:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        cmd.dir_up = dir_up_reg;
        s_tready   = 1'b0;
        emit       = 1'b0;
        case (state_reg)
            S_INIT:
                cmd.init_start = 1'b1;
            S_SWEEP:
                cmd.sweep_write = 1'b1;
            S_IDLE:
            begin
                s_tready      = 1'b1;
                cmd.load_item = accept;
                if (op_in == OP_DELETE && stat.live_le1)
                    cmd.status_code = ST_REFUSED;
                else if (op_in == OP_UNDO && stat.hist_empty)
                    cmd.status_code = ST_EMPTY_HISTORY;
                else
                    cmd.status_code = ST_OK;
            end
            S_MOVE_RD:
            begin
                cmd.addr_sel  = ADDR_CURSOR;
                cmd.link_read = 1'b1;
            end
            S_MOVE_STEP:
            begin
                cmd.addr_sel = ADDR_LINK;
                if (stat.link_valid)
                begin
                    cmd.move_advance = 1'b1;
                    cmd.link_read    = 1'b1;
                end
                else
                    cmd.set_edge = 1'b1;
            end
            S_DEL_RD:
            begin
                cmd.addr_sel  = ADDR_CURSOR;
                cmd.link_read = 1'b1;
            end
            S_DEL_WR:
                cmd.del_write = 1'b1;
            S_UNDO_HIST:
                cmd.hist_read = 1'b1;
            S_UNDO_LINK:
            begin
                cmd.addr_sel  = ADDR_HIST;
                cmd.link_read = 1'b1;
            end
            S_UNDO_WR:
                cmd.undo_write = 1'b1;
            S_QUERY_RD:
                cmd.mark_read = 1'b1;
            S_QUERY_TAKE:
                cmd.mark_take = 1'b1;
            S_DONE:
                emit = out_free;
            default:
                emit = 1'b0;
        endcase
    end

endmodule

### rtl/lrt_datapath.sv
// Link, mark and history memories plus cursor and counters of the row table.
// Depends on lrt_pkg; acts only on commands from lrt_ctrl.
module lrt_datapath
    import lrt_pkg::*;
#(
    parameter int MAX_ROWS = 1024
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  dp_cmd_t                cmd,
    output dp_stat_t               stat,
    input  logic [ROW_COUNT_W-1:0] row_count,
    input  logic [ROW_FIELD_W-1:0] start_row,
    input  logic [STEP_W-1:0]      step_count,
    input  logic [ROW_FIELD_W-1:0] row_index,
    output logic [ROW_FIELD_W-1:0] cursor_row,
    output logic                   row_deleted,
    output status_t                status
);

    localparam int DEPTH      = (MAX_ROWS < ROW_LIMIT) ? MAX_ROWS : ROW_LIMIT;
    localparam int ROW_W      = $clog2(DEPTH);
    localparam int CNT_W      = ROW_W + 1;
    localparam int RESET_ROWS = (RESET_ROW_COUNT < DEPTH) ? RESET_ROW_COUNT : DEPTH;
    localparam logic [CNT_W-1:0]       NO_LINK   = '1;
    localparam logic [CNT_W-1:0]       DEPTH_C   = CNT_W'(DEPTH);
    localparam logic [ROW_COUNT_W-1:0] DEPTH_CNT = ROW_COUNT_W'(DEPTH);

    // Memories; a missing neighbour is stored as all ones.
    logic [CNT_W-1:0] prev_mem [DEPTH];
    logic [CNT_W-1:0] next_mem [DEPTH];
    logic             mark_mem [DEPTH];
    logic [ROW_W-1:0] hist_mem [DEPTH];

    logic [CNT_W-1:0]  rows_reg;
    logic [CNT_W-1:0]  live_reg;
    logic [CNT_W-1:0]  depth_reg;
    logic [ROW_W-1:0]  cursor_reg;
    logic [ROW_W-1:0]  sweep_idx_reg;
    logic [STEP_W-1:0] remaining_reg;
    logic [ROW_FIELD_W-1:0] qrow_reg;
    status_t           status_reg;
    logic              dmark_reg;

    logic [CNT_W-1:0]  prev_rd_reg;
    logic [CNT_W-1:0]  next_rd_reg;
    logic [ROW_W-1:0]  hist_rd_reg;
    logic              mark_rd_reg;

    logic [ROW_COUNT_W-1:0] eff_wide;
    logic [ROW_W-1:0]       init_cursor;
    logic [CNT_W-1:0]       link_sel;
    logic                   l_valid, r_valid, row_valid, q_valid;
    logic [ROW_W-1:0]       link_raddr;
    logic [CNT_W-1:0]       depth_dec;
    logic [CNT_W-1:0]       sweep_succ;
    logic [CNT_W-1:0]       sweep_prev, sweep_next;

    logic             prev_we, next_we, mark_we, hist_we;
    logic [ROW_W-1:0] prev_waddr, next_waddr, mark_waddr;
    logic [CNT_W-1:0] prev_wdata, next_wdata;
    logic             mark_wdata;

    // Effective row count: zero counts as one, large counts saturate.
    always_comb
    begin
        eff_wide = row_count;
        if (row_count == '0)
            eff_wide = ROW_COUNT_W'(1);
        else if (row_count > DEPTH_CNT)
            eff_wide = DEPTH_CNT;
        if (ROW_COUNT_W'(start_row) < eff_wide)
            init_cursor = ROW_W'(start_row);
        else
            init_cursor = ROW_W'(eff_wide - ROW_COUNT_W'(1));
    end

    assign link_sel   = cmd.dir_up ? prev_rd_reg : next_rd_reg;
    assign l_valid    = prev_rd_reg < rows_reg;
    assign r_valid    = next_rd_reg < rows_reg;
    assign row_valid  = CNT_W'(hist_rd_reg) < rows_reg;
    assign q_valid    = ROW_COUNT_W'(qrow_reg) < ROW_COUNT_W'(rows_reg);
    assign depth_dec  = depth_reg - CNT_W'(1);
    assign sweep_succ = CNT_W'(sweep_idx_reg) + CNT_W'(1);
    assign sweep_prev = (sweep_idx_reg == '0) ? NO_LINK : CNT_W'(sweep_idx_reg) - CNT_W'(1);
    assign sweep_next = (sweep_succ < rows_reg) ? sweep_succ : NO_LINK;

    always_comb
    begin
        case (cmd.addr_sel)
            ADDR_CURSOR: link_raddr = cursor_reg;
            ADDR_LINK:   link_raddr = link_sel[ROW_W-1:0];
            ADDR_HIST:   link_raddr = hist_rd_reg;
            default:     link_raddr = cursor_reg;
        endcase
    end

    assign stat.live_le1   = live_reg <= CNT_W'(1);
    assign stat.hist_empty = depth_reg == '0;
    assign stat.steps_zero = remaining_reg == '0;
    assign stat.steps_one  = remaining_reg == STEP_W'(1);
    assign stat.link_valid = link_sel < rows_reg;
    assign stat.sweep_last = sweep_succ == rows_reg;

    // Write port selection for each memory.
    always_comb
    begin
        prev_we    = 1'b0;
        prev_waddr = sweep_idx_reg;
        prev_wdata = sweep_prev;
        next_we    = 1'b0;
        next_waddr = sweep_idx_reg;
        next_wdata = sweep_next;
        mark_we    = 1'b0;
        mark_waddr = sweep_idx_reg;
        mark_wdata = 1'b0;
        hist_we    = 1'b0;
        if (cmd.sweep_write)
        begin
            prev_we = 1'b1;
            next_we = 1'b1;
            mark_we = 1'b1;
        end
        else if (cmd.del_write)
        begin
            prev_we    = r_valid;
            prev_waddr = next_rd_reg[ROW_W-1:0];
            prev_wdata = prev_rd_reg;
            next_we    = l_valid;
            next_waddr = prev_rd_reg[ROW_W-1:0];
            next_wdata = next_rd_reg;
            mark_we    = 1'b1;
            mark_waddr = cursor_reg;
            mark_wdata = 1'b1;
            hist_we    = depth_reg < DEPTH_C;
        end
        else if (cmd.undo_write)
        begin
            prev_we    = r_valid && row_valid;
            prev_waddr = next_rd_reg[ROW_W-1:0];
            prev_wdata = CNT_W'(hist_rd_reg);
            next_we    = l_valid && row_valid;
            next_waddr = prev_rd_reg[ROW_W-1:0];
            next_wdata = CNT_W'(hist_rd_reg);
            mark_we    = row_valid;
            mark_waddr = hist_rd_reg;
            mark_wdata = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
            prev_mem[prev_waddr] <= prev_wdata;
        if (next_we)
            next_mem[next_waddr] <= next_wdata;
        if (mark_we)
            mark_mem[mark_waddr] <= mark_wdata;
        if (hist_we)
            hist_mem[depth_reg[ROW_W-1:0]] <= cursor_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.link_read)
        begin
            prev_rd_reg <= prev_mem[link_raddr];
            next_rd_reg <= next_mem[link_raddr];
        end
        if (cmd.hist_read)
            hist_rd_reg <= hist_mem[depth_dec[ROW_W-1:0]];
        if (cmd.mark_read)
            mark_rd_reg <= mark_mem[qrow_reg[ROW_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg      <= CNT_W'(RESET_ROWS);
            live_reg      <= CNT_W'(RESET_ROWS);
            depth_reg     <= '0;
            cursor_reg    <= '0;
            sweep_idx_reg <= '0;
            remaining_reg <= '0;
            qrow_reg      <= '0;
            status_reg    <= ST_OK;
            dmark_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.load_item)
            begin
                remaining_reg <= step_count;
                qrow_reg      <= row_index;
                status_reg    <= cmd.status_code;
                dmark_reg     <= 1'b0;
            end
            if (cmd.init_start)
            begin
                rows_reg      <= CNT_W'(eff_wide);
                live_reg      <= CNT_W'(eff_wide);
                depth_reg     <= '0;
                cursor_reg    <= init_cursor;
                sweep_idx_reg <= '0;
            end
            if (cmd.sweep_write)
                sweep_idx_reg <= sweep_idx_reg + ROW_W'(1);
            if (cmd.move_advance)
            begin
                cursor_reg    <= link_sel[ROW_W-1:0];
                remaining_reg <= remaining_reg - STEP_W'(1);
            end
            if (cmd.set_edge)
                status_reg <= ST_EDGE;
            if (cmd.del_write)
            begin
                live_reg <= live_reg - CNT_W'(1);
                if (depth_reg < DEPTH_C)
                    depth_reg <= depth_reg + CNT_W'(1);
                if (r_valid)
                    cursor_reg <= next_rd_reg[ROW_W-1:0];
                else if (l_valid)
                    cursor_reg <= prev_rd_reg[ROW_W-1:0];
            end
            if (cmd.undo_write)
            begin
                depth_reg <= depth_dec;
                if (row_valid)
                    live_reg <= live_reg + CNT_W'(1);
            end
            if (cmd.mark_take)
                dmark_reg <= q_valid && mark_rd_reg;
        end
    end

    assign cursor_row  = ROW_FIELD_W'(cursor_reg);
    assign row_deleted = dmark_reg;
    assign status      = status_reg;

    // Every deleted row sits on the undo history.
    assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W + 1)'(live_reg) + (CNT_W + 1)'(depth_reg) == (CNT_W + 1)'(rows_reg))
        else $error("live rows and history depth do not add up to the row count");

    assert property (@(posedge clk) disable iff (!rst_n) live_reg != '0)
        else $error("no live row left in the table");

    assert property (@(posedge clk) disable iff (!rst_n) CNT_W'(cursor_reg) < rows_reg)
        else $error("cursor outside the rows in use");

endmodule

### rtl/linked_row_table_with_undo.sv
// Linked row table with undo, built from lrt_pkg, lrt_ctrl and lrt_datapath. A request's
// result is issued, once the result register is free, directly for a refused delete, empty
// undo or unused code, after a mark read for a query, a link read and write for a delete, a
// history read, link read and write for an undo, one link per cycle for a move (stopping at
// an edge) and a sweep of all rows for an init; a further request is taken the cycle after.
// Reset is asynchronous and active low; a clearing pass then rebuilds links with s_tready low.
module linked_row_table_with_undo
    import lrt_pkg::*;
#(
    parameter int MAX_ROWS = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,  // operation, step_count, row_index, zero pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,  // cursor_row, row_deleted, status, zero pad
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers. They only take effect when the table is
    // initialised, either after reset or by an init request.
    logic [ROW_COUNT_W-1:0] row_count_reg;
    logic [ROW_FIELD_W-1:0] start_row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= ROW_COUNT_W'(RESET_ROW_COUNT);
            start_row_reg <= ROW_FIELD_W'(RESET_START_ROW);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_ROW_COUNT: row_count_reg <= cfg_data;
                CFG_START_ROW: start_row_reg <= cfg_data[ROW_FIELD_W-1:0];
                default:       row_count_reg <= row_count_reg;
            endcase
        end
    end

    // Request fields, lowest bits first.
    logic [OP_W-1:0]        op_code;
    logic [STEP_W-1:0]      step_count;
    logic [ROW_FIELD_W-1:0] row_index;

    assign op_code    = s_tdata[OP_W-1:0];
    assign step_count = s_tdata[OP_W +: STEP_W];
    assign row_index  = s_tdata[OP_W + STEP_W +: ROW_FIELD_W];

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     emit;
    logic     out_free;

    logic [ROW_FIELD_W-1:0] cursor_row;
    logic                   row_deleted;
    status_t                status;

    // The controller walks each request through its memory accesses; the
    // datapath owns the link, mark and history memories.
    lrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op_code  (op_code),
        .stat     (stat),
        .out_free (out_free),
        .cmd      (cmd),
        .emit     (emit)
    );

    lrt_datapath #(
        .MAX_ROWS (MAX_ROWS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .row_count   (row_count_reg),
        .start_row   (start_row_reg),
        .step_count  (step_count),
        .row_index   (row_index),
        .cursor_row  (cursor_row),
        .row_deleted (row_deleted),
        .status      (status)
    );

    // Result register. A finished result waits here, so the engine is free to
    // take the next request while the downstream side stalls.
    logic                   out_valid_reg;
    logic [ROW_FIELD_W-1:0] out_cursor_reg;
    logic                   out_deleted_reg;
    status_t                out_status_reg;

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_cursor_reg  <= cursor_row;
            out_deleted_reg <= row_deleted;
            out_status_reg  <= status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - ROW_FIELD_W - 1 - STATUS_W){1'b0}},
                       out_status_reg, out_deleted_reg, out_cursor_reg};

    // A result is never written over one that has not been taken.
    assert property (@(posedge clk) disable iff (!rst_n) emit |-> (!m_tvalid || m_tready))
        else $error("result register overwritten while full");

    // Only one request is in the engine at a time.
    assert property (@(posedge clk) disable iff (!rst_n) (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request accepted while one is in progress");

    // Once a result is issued the engine is back waiting for requests.
    assert property (@(posedge clk) disable iff (!rst_n) emit |=> (s_tready && m_tvalid))
        else $error("engine not ready after issuing a result");

endmodule

### test/tb_linked_row_table_with_undo.sv
// Self-checking testbench for the linked row table with undo.
// Depends on lrt_pkg and linked_row_table_with_undo; a built-in model of the
// row list predicts every result and a monitor compares them as they leave.
`timescale 1ns / 1ps

module tb_linked_row_table_with_undo;
    import lrt_pkg::*;

    // Row capacity given to the block, and the marker for a missing neighbour.
    localparam int         TABLE_ROWS      = 1024;
    localparam logic [10:0] NO_LINK        = 11'h7FF;
    // Operation codes that the block must ignore.
    localparam logic [2:0] OP_SPARE_LO     = 3'd6;
    localparam logic [2:0] OP_SPARE_HI     = 3'd7;
    // Cycles without any handshake before the run is declared hung. The slowest
    // request is an init or a move over a full table, and the deliberate sink
    // hold-off set by HOLD_OFF_CYCLES adds to the quiet time.
    localparam int         IDLE_LIMIT      = 20000;
    localparam int         SETTLE_CYCLES   = 6;
    localparam int         HOLD_OFF_CYCLES = 300;

    typedef struct packed {
        logic [ROW_FIELD_W-1:0] cursor_row;
        logic                   row_deleted;
        status_t                status;
    } row_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // operation, step_count, row_index, zero pad
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // cursor_row, row_deleted, status, zero pad
    logic                  cfg_we;
    cfg_reg_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    linked_row_table_with_undo #(
        .MAX_ROWS (TABLE_ROWS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Model of the row list. The register shadows only reach the list when
    // it is rebuilt, which happens at reset and on every init request.
    // ------------------------------------------------------------------
    logic [ROW_COUNT_W-1:0] shadow_row_count;
    logic [ROW_FIELD_W-1:0] shadow_start_row;

    logic [10:0]            up_link   [TABLE_ROWS];
    logic [10:0]            down_link [TABLE_ROWS];
    logic                   row_gone  [TABLE_ROWS];
    logic [ROW_FIELD_W-1:0] delete_stack [TABLE_ROWS];
    logic [10:0]            stack_depth;
    logic [10:0]            live_count;
    logic [10:0]            rows_in_list;
    logic [ROW_FIELD_W-1:0] cursor_pos;

    // Results predicted for accepted requests, oldest first.
    row_result_t            pending_results[$];
    int                     failures;

    // Traffic shaping, set by the test tasks.
    int                     source_idle_pct;
    int                     sink_stall_pct;
    int                     sink_hold_len;

    function automatic void rebuild_row_list();
        int rows;
        rows = int'(shadow_row_count);
        // A zero count still gives one row; large counts saturate.
        if (rows == 0)
            rows = 1;
        if (rows > ROW_LIMIT)
            rows = ROW_LIMIT;
        if (rows > TABLE_ROWS)
            rows = TABLE_ROWS;
        rows_in_list = 11'(rows);
        for (int i = 0; i < rows; i++)
        begin
            up_link[i]   = (i == 0) ? NO_LINK : 11'(i - 1);
            down_link[i] = (i + 1 < rows) ? 11'(i + 1) : NO_LINK;
            row_gone[i]  = 1'b0;
        end
        stack_depth = '0;
        live_count  = rows_in_list;
        // A start row past the end puts the cursor on the last row.
        cursor_pos  = (shadow_start_row < rows_in_list) ? shadow_start_row
                                                        : 10'(rows_in_list - 11'd1);
    endfunction

    function automatic row_result_t predict_row_list(logic [OP_W-1:0] op,
                                                     logic [STEP_W-1:0] steps,
                                                     logic [ROW_FIELD_W-1:0] query_row);
        row_result_t res;
        logic [10:0] link;
        logic [10:0] left;
        logic [10:0] right;
        logic [ROW_FIELD_W-1:0] row;
        res.status      = ST_OK;
        res.row_deleted = 1'b0;
        case (op)
            OP_INIT:
                rebuild_row_list();
            OP_UP, OP_DOWN:
            begin
                // Follow one link per step; the first missing link stops the move.
                for (int i = 0; i < steps; i++)
                begin
                    link = (op == OP_UP) ? up_link[cursor_pos] : down_link[cursor_pos];
                    if (link >= rows_in_list)
                    begin
                        res.status = ST_EDGE;
                        break;
                    end
                    cursor_pos = link[ROW_FIELD_W-1:0];
                end
            end
            OP_DELETE:
            begin
                if (live_count <= 11'd1)
                    res.status = ST_REFUSED;
                else
                begin
                    left  = up_link[cursor_pos];
                    right = down_link[cursor_pos];
                    row_gone[cursor_pos] = 1'b1;
                    if (stack_depth < 11'(TABLE_ROWS))
                    begin
                        delete_stack[stack_depth[ROW_FIELD_W-1:0]] = cursor_pos;
                        stack_depth = stack_depth + 11'd1;
                    end
                    live_count = live_count - 11'd1;
                    // The deleted row keeps its own links for a later undo.
                    if (right < rows_in_list)
                        up_link[right[ROW_FIELD_W-1:0]] = left;
                    if (left < rows_in_list)
                        down_link[left[ROW_FIELD_W-1:0]] = right;
                    if (right < rows_in_list)
                        cursor_pos = right[ROW_FIELD_W-1:0];
                    else if (left < rows_in_list)
                        cursor_pos = left[ROW_FIELD_W-1:0];
                end
            end
            OP_UNDO:
            begin
                if (stack_depth == '0)
                    res.status = ST_EMPTY_HISTORY;
                else
                begin
                    stack_depth = stack_depth - 11'd1;
                    row = delete_stack[stack_depth[ROW_FIELD_W-1:0]];
                    if (11'(row) < rows_in_list)
                    begin
                        left  = up_link[row];
                        right = down_link[row];
                        row_gone[row] = 1'b0;
                        live_count = live_count + 11'd1;
                        if (left < rows_in_list)
                            down_link[left[ROW_FIELD_W-1:0]] = 11'(row);
                        if (right < rows_in_list)
                            up_link[right[ROW_FIELD_W-1:0]] = 11'(row);
                    end
                end
            end
            OP_QUERY:
            begin
                if (11'(query_row) < rows_in_list)
                    res.row_deleted = row_gone[query_row];
            end
            default:
                ;
        endcase
        res.cursor_row = cursor_pos;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request side. Every call starts and ends on a rising edge; tvalid is
    // left high after acceptance so that back-to-back requests never lower
    // and raise it within the same time step.
    // ------------------------------------------------------------------
    task automatic send_request(input logic [OP_W-1:0] op,
                                input logic [STEP_W-1:0] steps,
                                input logic [ROW_FIELD_W-1:0] query_row);
        int gap;
        row_result_t expected;
        gap = 0;
        while ($urandom_range(99) < source_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, query_row, steps, op};
        do
            @(posedge clk);
        while (!s_tready);
        expected        = predict_row_list(op, steps, query_row);
        pending_results = {pending_results, expected};
    endtask

    // Stop offering requests and wait until every predicted result is back.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Program both registers while the block is idle, then rebuild the list
    // with an init request so that the new values take effect.
    task automatic apply_setting(input logic [ROW_COUNT_W-1:0] rows,
                                 input logic [ROW_FIELD_W-1:0] start);
        wait_for_results();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ROW_COUNT;
        cfg_data  <= rows;
        @(posedge clk);
        shadow_row_count = rows;
        cfg_index <= CFG_START_ROW;
        cfg_data  <= CFG_DATA_W'(start);
        @(posedge clk);
        shadow_start_row = start;
        cfg_we <= 1'b0;
        send_request(OP_INIT, STEP_W'($urandom_range(1023)),
                     ROW_FIELD_W'($urandom_range(1023)));
    endtask

    task automatic set_traffic(input int source_pct, input int sink_pct);
        source_idle_pct = source_pct;
        sink_stall_pct  = sink_pct;
    endtask

    // One request with a random operation. Step counts are mostly short so
    // that large tables stay quick, with the odd full-range one.
    task automatic send_random_request();
        logic [OP_W-1:0]        op;
        logic [STEP_W-1:0]      steps;
        logic [ROW_FIELD_W-1:0] query_row;
        int pick;
        pick = $urandom_range(99);
        if (pick < 20)
            op = OP_UP;
        else if (pick < 40)
            op = OP_DOWN;
        else if (pick < 60)
            op = OP_DELETE;
        else if (pick < 75)
            op = OP_UNDO;
        else if (pick < 93)
            op = OP_QUERY;
        else if (pick < 96)
            op = OP_INIT;
        else
            op = $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
        pick = $urandom_range(9);
        if (pick < 7)
            steps = STEP_W'($urandom_range(7));
        else if (pick < 9)
            steps = (rows_in_list > 1023) ? STEP_W'($urandom_range(1023))
                                          : STEP_W'($urandom_range(rows_in_list));
        else
            steps = STEP_W'($urandom_range(1023));
        if ($urandom_range(9) < 7)
            query_row = ROW_FIELD_W'($urandom_range(rows_in_list - 1));
        else
            query_row = ROW_FIELD_W'($urandom_range(1023));
        send_request(op, steps, query_row);
    endtask

    // A run of deletes, sometimes with a short move in between, followed by
    // a run of undos that may overshoot the history, and a final query.
    task automatic send_edit_burst(output int sent);
        int deletes;
        int undos;
        sent    = 0;
        deletes = $urandom_range(12, 1);
        undos   = $urandom_range(deletes + 2, 1);
        repeat (deletes)
        begin
            if ($urandom_range(3) == 0)
            begin
                send_request($urandom_range(1) ? OP_UP : OP_DOWN, STEP_W'($urandom_range(3)),
                             ROW_FIELD_W'($urandom_range(1023)));
                sent++;
            end
            send_request(OP_DELETE, STEP_W'($urandom_range(1023)),
                         ROW_FIELD_W'($urandom_range(1023)));
            sent++;
        end
        repeat (undos)
        begin
            send_request(OP_UNDO, STEP_W'($urandom_range(1023)),
                         ROW_FIELD_W'($urandom_range(1023)));
            sent++;
        end
        send_request(OP_QUERY, 10'd0, ROW_FIELD_W'($urandom_range(rows_in_list - 1)));
        sent++;
    endtask

    // Settings visited by the random phases, the register extremes among them.
    task automatic pick_setting(input int idx, output logic [ROW_COUNT_W-1:0] rows,
                                output logic [ROW_FIELD_W-1:0] start);
        case (idx % 11)
            0:  begin rows = 11'd5;    start = 10'd2;    end
            1:  begin rows = 11'd16;   start = 10'd20;   end
            2:  begin rows = 11'd2;    start = 10'd1;    end
            3:  begin rows = 11'd1024; start = 10'd1023; end
            4:  begin rows = 11'd37;   start = 10'd0;    end
            5:  begin rows = 11'd1;    start = 10'd0;    end
            6:  begin rows = 11'd64;   start = 10'd63;   end
            7:  begin rows = 11'd2047; start = 10'd0;    end
            8:  begin rows = 11'd8;    start = 10'd3;    end
            9:  begin rows = 11'd0;    start = 10'd1023; end
            default: begin rows = 11'd130; start = 10'd77; end
        endcase
    endtask

    // Four settings per phase; big tables get only a handful of requests.
    task automatic run_random_phase(input int phase_no, input int items);
        logic [ROW_COUNT_W-1:0] rows;
        logic [ROW_FIELD_W-1:0] start;
        int budget;
        int sent;
        int burst;
        for (int chunk = 0; chunk < 4; chunk++)
        begin
            pick_setting(phase_no * 4 + chunk, rows, start);
            apply_setting(rows, start);
            budget = (rows > 11'd256) ? 30 : items / 4;
            sent   = 0;
            while (sent < budget)
            begin
                if ($urandom_range(99) < 8)
                begin
                    send_edit_burst(burst);
                    sent += burst;
                end
                else
                begin
                    send_random_request();
                    sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test tasks.
    // ------------------------------------------------------------------

    // Field extremes, every operation and each corner of the list, starting
    // from the register values that reset leaves behind.
    task automatic test_directed_cases();
        set_traffic(0, 0);
        send_request(OP_QUERY, 10'd0, 10'd0);
        send_request(OP_UP, 10'd1, 10'd0);              // already on the first row
        send_request(OP_DOWN, 10'd0, 10'd0);            // zero steps, no movement
        send_request(OP_DOWN, 10'd1023, 10'd1023);      // runs into the last row
        send_request(OP_DELETE, 10'd0, 10'd0);          // last row goes, cursor steps back
        send_request(OP_QUERY, 10'd0, 10'd7);
        send_request(OP_QUERY, 10'd0, 10'd1023);        // beyond the row count
        send_request(OP_UNDO, 10'd0, 10'd0);            // cursor must stay put
        send_request(OP_QUERY, 10'd0, 10'd7);
        send_request(OP_UNDO, 10'd0, 10'd0);            // history now empty
        send_request(OP_SPARE_LO, 10'd1023, 10'd1023);
        send_request(OP_SPARE_HI, 10'd0, 10'd0);
        // A zero row count still gives one row, and the start row is clamped.
        apply_setting(11'd0, 10'd1023);
        send_request(OP_DELETE, 10'd0, 10'd0);          // the only live row stays
        send_request(OP_UNDO, 10'd0, 10'd0);
        send_request(OP_UP, 10'd5, 10'd0);
        // An oversized count saturates to the full table.
        apply_setting(11'd2047, 10'd1023);
        send_request(OP_DOWN, 10'd1, 10'd0);
        send_request(OP_UP, 10'd1023, 10'd0);           // exactly reaches the first row
        send_request(OP_QUERY, 10'd0, 10'd1023);
        // Delete down to one live row, then undo everything.
        apply_setting(11'd3, 10'd2);
        send_request(OP_DELETE, 10'd0, 10'd0);
        send_request(OP_DELETE, 10'd0, 10'd0);
        send_request(OP_DELETE, 10'd0, 10'd0);
        send_request(OP_UNDO, 10'd0, 10'd0);
        send_request(OP_UNDO, 10'd0, 10'd0);
        send_request(OP_QUERY, 10'd0, 10'd2);
    endtask

    // The sink stops for a long stretch while requests keep coming, so the
    // block fills and holds s_tready low; the sender then waits for all
    // results before carrying on.
    task automatic test_sink_hold_off();
        set_traffic(0, 0);
        apply_setting(11'd12, 10'd5);
        sink_hold_len = HOLD_OFF_CYCLES;
        repeat (20) send_random_request();
        wait_for_results();
        repeat (10) send_random_request();
    endtask

    task automatic test_steady_flow();
        set_traffic(0, 0);
        run_random_phase(0, 540);
    endtask

    task automatic test_sparse_requests();
        set_traffic(80, 0);
        run_random_phase(1, 540);
    endtask

    task automatic test_slow_sink();
        set_traffic(0, 80);
        run_random_phase(2, 540);
    endtask

    task automatic test_light_gaps();
        set_traffic(9, 9);
        run_random_phase(3, 540);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, plus a hold-off counted here in cycles.
    // ------------------------------------------------------------------
    int hold_left;

    always @(posedge clk)
    begin
        if (sink_hold_len != 0)
        begin
            hold_left     = sink_hold_len;
            sink_hold_len = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge clk)
    begin : result_monitor
        row_result_t got;
        row_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.cursor_row  = m_tdata[ROW_FIELD_W-1:0];
            got.row_deleted = m_tdata[ROW_FIELD_W];
            got.status      = status_t'(m_tdata[ROW_FIELD_W+STATUS_W:ROW_FIELD_W+1]);
            if (pending_results.size() == 0)
            begin
                $error("result arrived with no request outstanding");
                failures++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.cursor_row !== want.cursor_row)
                begin
                    $error("cursor_row: expected %0d, got %0d", want.cursor_row, got.cursor_row);
                    failures++;
                end
                if (got.row_deleted !== want.row_deleted)
                begin
                    $error("row_deleted: expected %0d, got %0d",
                           want.row_deleted, got.row_deleted);
                    failures++;
                end
                if (got.status !== want.status)
                begin
                    $error("status: expected %s, got %s", want.status.name(),
                           got.status.name());
                    failures++;
                end
            end
        end
    end

    // Watchdog: too long without any handshake on either side ends the run.
    int quiet_cycles;

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        m_tready        = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_ROW_COUNT;
        cfg_data        = '0;
        failures        = 0;
        source_idle_pct = 0;
        sink_stall_pct  = 0;
        sink_hold_len   = 0;
        hold_left       = 0;
        quiet_cycles    = 0;
        shadow_row_count = ROW_COUNT_W'(RESET_ROW_COUNT);
        shadow_start_row = ROW_FIELD_W'(RESET_START_ROW);
        rebuild_row_list();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_sink_hold_off();
        test_steady_flow();
        test_sparse_requests();
        test_slow_sink();
        test_light_gaps();

        wait_for_results();
        repeat (20) @(posedge clk);
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### linked_row_table_with_undo.f
rtl/lrt_pkg.sv
rtl/lrt_ctrl.sv
rtl/lrt_datapath.sv
rtl/linked_row_table_with_undo.sv
test/tb_linked_row_table_with_undo.sv
